// ===== hdl/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and constants for the line tag cache: op codes, stream
// layouts and the per-entry result of the range shift unit.
// ----------------------------------------------------------------------------
package ltc_pkg;

  // Op codes carried in the low bits of the input item
  localparam logic [2:0] OP_GET   = 3'd0;
  localparam logic [2:0] OP_PUT   = 3'd1;
  localparam logic [2:0] OP_INV   = 3'd2;
  localparam logic [2:0] OP_RANGE = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned S_TDATA_W = 232;
  localparam int unsigned M_TDATA_W = 40;

  // Arithmetic width of the shift unit: holds any 64-bit key plus sign
  localparam int unsigned XW = 66;

  typedef struct packed {
    logic kill;   // entry leaves the table
    logic moved;  // entry takes a shifted key
  } shift_res_t;

endpackage

// ===== hdl/ltc_shift_unit.sv =====
// ----------------------------------------------------------------------------
// ltc_shift_unit
// Shared range unit: classifies one entry against the removed range and
// computes its shifted key, dropping keys that leave the key space.
// ----------------------------------------------------------------------------
module ltc_shift_unit #(
  parameter int unsigned LINE_BITS = 32
) (
  input  logic                   valid_i,
  input  logic [LINE_BITS-1:0]   key_i,
  input  logic [31:0]            first_i,
  input  logic [31:0]            count_i,
  input  logic signed [31:0]     delta_i,
  output ltc_pkg::shift_res_t    res_o,
  output logic [LINE_BITS-1:0]   newkey_o
);
  import ltc_pkg::*;

  logic [XW-1:0] kx, fx, diff, sum, kmax;
  logic          ge, in_rng, nz, neg, over;

  always_comb begin
    kx     = XW'(key_i);
    fx     = XW'(first_i);
    kmax   = XW'({LINE_BITS{1'b1}});
    ge     = kx >= fx;
    diff   = kx - fx;
    in_rng = diff < XW'(count_i);
    sum    = kx + {{(XW-32){delta_i[31]}}, delta_i};
    nz     = delta_i != 32'sd0;
    neg    = sum[XW-1];
    over   = !neg && (sum > kmax);
    res_o.kill  = valid_i && ge && (in_rng || (nz && (neg || over)));
    res_o.moved = valid_i && ge && !in_rng && nz && !neg && !over;
    newkey_o    = sum[LINE_BITS-1:0];
  end

endmodule

// ===== hdl/lru_line_tag_cache.sv =====
// ----------------------------------------------------------------------------
// lru_line_tag_cache
// Fully associative LRU table of line tags with hash check, range removal
// and key renumbering, run by a small sequencer around one shift unit.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Content
// s_axis    in   tvalid/tready          op, line, hash, payload, range, delta
// m_axis    out  tvalid/tready          hit, hit_payload, entries_used
// cfg       in   cfg_we_i               capacity (5 bits)
//
// get, put of a present key, invalidate and clear go through the execute and
// done states; put of a new key adds an evict and an insert state. invalidate
// range: the shift unit visits one entry per cycle in the scan sweep, then a
// collision sweep and a rank repack sweep each go over all entries.
// One item at a time: tready is high only while the sequencer is idle.
// The result sits in an output register until taken; a new item is accepted
// meanwhile. Reset empties the table and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_line_tag_cache #(
  parameter int unsigned ENTRIES      = 16,
  parameter int unsigned LINE_BITS    = 32,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // lo->hi: op[3] line[32] hash[64] payload[32] range_first[32]
  //         range_count[32] shift[32] zero pad[5]
  input  logic [ltc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // lo->hi: hit[1] hit_payload[32] entries_used[5] zero pad[2]
  output logic [ltc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [4:0]                     cfg_wdata_i
);
  import ltc_pkg::*;

  localparam int unsigned AW    = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned EW    = (CNT_W > 5) ? CNT_W : 5;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_EVICT = 4'd2;
  localparam logic [3:0] S_INS   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_COLL  = 4'd5;
  localparam logic [3:0] S_PACK  = 4'd6;
  localparam logic [3:0] S_PACKW = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Control state
  logic [3:0]   state_q, state_d;
  logic [4:0]   cap_q;
  logic         ovld_q, ovld_d;
  logic         valid_q [ENTRIES];
  logic         valid_d [ENTRIES];

  // Table contents
  logic [LINE_BITS-1:0]    line_q [ENTRIES];
  logic [LINE_BITS-1:0]    line_d [ENTRIES];
  logic [63:0]             ehash_q [ENTRIES];
  logic [63:0]             ehash_d [ENTRIES];
  logic [PAYLOAD_BITS-1:0] handle_q [ENTRIES];
  logic [PAYLOAD_BITS-1:0] handle_d [ENTRIES];
  logic [AW-1:0]           age_q [ENTRIES];
  logic [AW-1:0]           age_d [ENTRIES];
  logic [AW-1:0]           dec_q [ENTRIES];
  logic [AW-1:0]           dec_d [ENTRIES];
  logic                    moved_q [ENTRIES];
  logic                    moved_d [ENTRIES];
  logic                    vold_q [ENTRIES];
  logic                    vold_d [ENTRIES];

  // Captured item
  logic [2:0]              op_q, op_d;
  logic [LINE_BITS-1:0]    key_q, key_d;
  logic [63:0]             hash_q, hash_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [31:0]             first_q, first_d, count_q, count_d;
  logic signed [31:0]      delta_q, delta_d;
  logic                    hit_q, hit_d;
  logic [PAYLOAD_BITS-1:0] hpay_q, hpay_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [M_TDATA_W-1:0]    odata_q, odata_d;

  // Lookup and helpers
  logic          found;
  logic [AW-1:0] slot;
  logic [AW-1:0] free_slot;
  logic [EW-1:0] cap_eff;
  logic [EW-1:0] used_cnt;
  logic          last_idx;
  shift_res_t    sres;
  logic [LINE_BITS-1:0] skey;

  ltc_shift_unit #(.LINE_BITS(LINE_BITS)) u_shift (
    .valid_i  (valid_q[idx_q]),
    .key_i    (line_q[idx_q]),
    .first_i  (first_q),
    .count_i  (count_q),
    .delta_i  (delta_q),
    .res_o    (sres),
    .newkey_o (skey)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign last_idx      = (idx_q == AW'(ENTRIES - 1));

  // Parallel key match, first free slot, occupancy, effective capacity
  always_comb begin
    found     = 1'b0;
    slot      = '0;
    free_slot = '0;
    used_cnt  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && line_q[i] == key_q) begin
        found = 1'b1;
        slot  = AW'(i);
      end
      if (!valid_q[i]) free_slot = AW'(i);
      used_cnt = used_cnt + EW'(valid_q[i]);
    end
    if (cap_q == 5'd0)                 cap_eff = EW'(1);
    else if (EW'(cap_q) > EW'(ENTRIES)) cap_eff = EW'(ENTRIES);
    else                                cap_eff = EW'(cap_q);
  end

  always_comb begin
    state_d = state_q;
    ovld_d  = ovld_q;
    op_d    = op_q;
    key_d   = key_q;
    hash_d  = hash_q;
    pay_d   = pay_q;
    first_d = first_q;
    count_d = count_q;
    delta_d = delta_q;
    hit_d   = hit_q;
    hpay_d  = hpay_q;
    idx_d   = idx_q;
    odata_d = odata_q;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_d[i]  = valid_q[i];
      line_d[i]   = line_q[i];
      ehash_d[i]  = ehash_q[i];
      handle_d[i] = handle_q[i];
      age_d[i]    = age_q[i];
      dec_d[i]    = dec_q[i];
      moved_d[i]  = moved_q[i];
      vold_d[i]   = vold_q[i];
    end

    // Drop the result once taken
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = s_axis_tdata[2:0];
          key_d   = LINE_BITS'(s_axis_tdata[34:3]);
          hash_d  = s_axis_tdata[98:35];
          pay_d   = PAYLOAD_BITS'(s_axis_tdata[130:99]);
          first_d = s_axis_tdata[162:131];
          count_d = s_axis_tdata[194:163];
          delta_d = s_axis_tdata[226:195];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        hit_d   = 1'b0;
        hpay_d  = '0;
        state_d = S_DONE;
        case (op_q)
          OP_GET: begin
            if (found && ehash_q[slot] == hash_q) begin
              hit_d  = 1'b1;
              hpay_d = handle_q[slot];
              for (int i = 0; i < ENTRIES; i++)
                if (valid_q[i] && age_q[i] < age_q[slot]) age_d[i] = age_q[i] + 1'b1;
              age_d[slot] = '0;
            end
          end
          OP_PUT: begin
            if (found) begin
              ehash_d[slot]  = hash_q;
              handle_d[slot] = pay_q;
              for (int i = 0; i < ENTRIES; i++)
                if (valid_q[i] && age_q[i] < age_q[slot]) age_d[i] = age_q[i] + 1'b1;
              age_d[slot] = '0;
            end else begin
              state_d = S_EVICT;
            end
          end
          OP_INV: begin
            if (found) begin
              valid_d[slot] = 1'b0;
              for (int i = 0; i < ENTRIES; i++)
                if (valid_q[i] && age_q[i] > age_q[slot]) age_d[i] = age_q[i] - 1'b1;
            end
          end
          OP_RANGE: begin
            idx_d = '0;
            for (int i = 0; i < ENTRIES; i++) begin
              vold_d[i]  = valid_q[i];
              moved_d[i] = 1'b0;
              dec_d[i]   = '0;
            end
            state_d = S_SCAN;
          end
          OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) valid_d[i] = 1'b0;
          end
          default: ;
        endcase
      end
      S_EVICT: begin
        // Ranks are packed, so dropping the top ranks leaves cap-1 entries
        for (int i = 0; i < ENTRIES; i++)
          if (valid_q[i] && EW'(age_q[i]) >= cap_eff - EW'(1)) valid_d[i] = 1'b0;
        state_d = S_INS;
      end
      S_INS: begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid_q[i]) age_d[i] = age_q[i] + 1'b1;
        valid_d[free_slot]  = 1'b1;
        line_d[free_slot]   = key_q;
        ehash_d[free_slot]  = hash_q;
        handle_d[free_slot] = pay_q;
        age_d[free_slot]    = '0;
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (sres.kill) valid_d[idx_q] = 1'b0;
        if (sres.moved) begin
          moved_d[idx_q] = 1'b1;
          line_d[idx_q]  = skey;
        end
        idx_d = idx_q + 1'b1;
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_COLL;
        end
      end
      S_COLL: begin
        // A renumbered key replaces an unmoved entry holding the same key
        if (moved_q[idx_q] && valid_q[idx_q]) begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid_q[i] && !moved_q[i] && line_q[i] == line_q[idx_q])
              valid_d[i] = 1'b0;
        end
        idx_d = idx_q + 1'b1;
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_PACK;
        end
      end
      S_PACK: begin
        if (vold_q[idx_q] && !valid_q[idx_q]) begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid_q[i] && age_q[i] > age_q[idx_q]) dec_d[i] = dec_q[i] + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_PACKW;
        end
      end
      S_PACKW: begin
        for (int i = 0; i < ENTRIES; i++) age_d[i] = age_q[i] - dec_q[i];
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!ovld_q || m_axis_tready) begin
          odata_d = {2'b00, used_cnt[4:0], 32'(hpay_q), hit_q};
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      cap_q   <= 5'd16;
      for (int i = 0; i < ENTRIES; i++) valid_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      for (int i = 0; i < ENTRIES; i++) valid_q[i] <= valid_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    hash_q  <= hash_d;
    pay_q   <= pay_d;
    first_q <= first_d;
    count_q <= count_d;
    delta_q <= delta_d;
    hit_q   <= hit_d;
    hpay_q  <= hpay_d;
    idx_q   <= idx_d;
    odata_q <= odata_d;
    for (int i = 0; i < ENTRIES; i++) begin
      line_q[i]   <= line_d[i];
      ehash_q[i]  <= ehash_d[i];
      handle_q[i] <= handle_d[i];
      age_q[i]    <= age_d[i];
      dec_q[i]    <= dec_d[i];
      moved_q[i]  <= moved_d[i];
      vold_q[i]   <= vold_d[i];
    end
  end

endmodule

// ===== hdl/ltc_checker.sv =====
// ----------------------------------------------------------------------------
// ltc_checker
// Port-level checks for the line tag cache, bound to the top level.
// ----------------------------------------------------------------------------
module ltc_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [ltc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);
  import ltc_pkg::*;

  // One item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a second item back to back");

  // A miss reports a zero handle
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
    else $error("nonzero handle on a miss");

  // Occupancy never exceeds the table size
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[37:33]) <= ENTRIES)
    else $error("entries_used above table size");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind lru_line_tag_cache ltc_checker #(.ENTRIES(ENTRIES)) u_ltc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
